// File: rtl/mr256_pkg.sv
// Shared types and constants for the Montgomery reducer.
package mr256_pkg;
	localparam int LIMB_W = 64;
	localparam int HALF_W = 32;
	localparam int ROUNDS = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MOD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NINV = 3'd4;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [2*LIMB_W-1:0] dlimb_t;
	typedef logic [8*LIMB_W-1:0] wide_t;
	typedef logic [4*LIMB_W-1:0] elem_t;
	typedef logic [5*LIMB_W-1:0] kp_t;

	typedef struct packed {
		elem_t modulus;
		limb_t neg_inverse;
	} cfg_t;
endpackage

// File: rtl/mr256_round.sv
// One pipelined reduction round: quotient digit, k times p, accumulate.
module mr256_round
	import mr256_pkg::*;
#(
	parameter int ROUND = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	input  wide_t in_acc,
	output logic  out_valid,
	output wide_t out_acc
);
	localparam int SHIFT = LIMB_W * ROUND;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	wide_t acc_s1, acc_s2, acc_s3, acc_s4, acc_s5, acc_s6;
	logic [2*HALF_W-1:0] pk0_s1;
	logic [HALF_W-1:0] pk1_s1, pk2_s1;
	limb_t k_s2;
	logic [2*HALF_W-1:0] pp_s3 [4][4];
	dlimb_t prod_s4 [4];
	kp_t kp_s5;

	limb_t w_low;
	limb_t pk0_w, pk1_w, pk2_w;

	assign w_low = in_acc[SHIFT +: LIMB_W];
	assign pk0_w = {32'd0, w_low[HALF_W-1:0]} * {32'd0, cfg.neg_inverse[HALF_W-1:0]};
	assign pk1_w = {32'd0, w_low[HALF_W-1:0]} * {32'd0, cfg.neg_inverse[LIMB_W-1:HALF_W]};
	assign pk2_w = {32'd0, w_low[LIMB_W-1:HALF_W]} * {32'd0, cfg.neg_inverse[HALF_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		acc_s1 <= in_acc;
		pk0_s1 <= pk0_w;
		pk1_s1 <= pk1_w[HALF_W-1:0];
		pk2_s1 <= pk2_w[HALF_W-1:0];

		acc_s2 <= acc_s1;
		k_s2   <= pk0_s1 + {pk1_s1 + pk2_s1, 32'd0};

		acc_s3 <= acc_s2;
		for (int j = 0; j < 4; j++) begin
			for (int q = 0; q < 4; q++) begin
				pp_s3[j][q] <= {32'd0, k_s2[(q/2)*HALF_W +: HALF_W]}
					* {32'd0, cfg.modulus[j*LIMB_W + (q%2)*HALF_W +: HALF_W]};
			end
		end

		acc_s4 <= acc_s3;
		for (int j = 0; j < 4; j++) begin
			prod_s4[j] <= {64'd0, pp_s3[j][0]}
				+ {32'd0, pp_s3[j][1], 32'd0}
				+ {32'd0, pp_s3[j][2], 32'd0}
				+ {pp_s3[j][3], 64'd0};
		end

		acc_s5 <= acc_s4;
		kp_s5  <= {192'd0, prod_s4[0]} + {128'd0, prod_s4[1], 64'd0}
			+ {64'd0, prod_s4[2], 128'd0} + {prod_s4[3], 192'd0};

		acc_s6 <= acc_s5 + ({192'd0, kp_s5} << SHIFT);
	end

	assign out_valid = v_s6;
	assign out_acc   = acc_s6;
endmodule

// File: rtl/montgomery_reduce_256_top.sv
// Top level of the pipelined 256-bit Montgomery reducer.
// Accepts one word per cycle whenever start is high (busy stays low); each result
// appears for one cycle with done high after passing four rounds of six stages
// (quotient digit, k times p in 32-bit partial products, accumulate) plus one
// stage for the final conditional subtraction. Results cannot be held off.
module montgomery_reduce_256_top
	import mr256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] wide_limb_0,
	input  logic [63:0] wide_limb_1,
	input  logic [63:0] wide_limb_2,
	input  logic [63:0] wide_limb_3,
	input  logic [63:0] wide_limb_4,
	input  logic [63:0] wide_limb_5,
	input  logic [63:0] wide_limb_6,
	input  logic [63:0] wide_limb_7,
	output logic        done,
	output logic [63:0] reduced_limb_0,
	output logic [63:0] reduced_limb_1,
	output logic [63:0] reduced_limb_2,
	output logic [63:0] reduced_limb_3
);
	limb_t mod_q [4];
	limb_t ninv_q;
	cfg_t  cfg;

	logic  v [ROUNDS+1];
	wide_t acc [ROUNDS+1];

	logic [4*LIMB_W:0] diff;
	logic  done_q;
	elem_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) mod_q[i] <= '0;
			ninv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOD0: mod_q[0] <= cfg_data;
				REG_MOD1: mod_q[1] <= cfg_data;
				REG_MOD2: mod_q[2] <= cfg_data;
				REG_MOD3: mod_q[3] <= cfg_data;
				REG_NINV: ninv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.modulus     = {mod_q[3], mod_q[2], mod_q[1], mod_q[0]};
	assign cfg.neg_inverse = ninv_q;

	assign busy   = 1'b0;
	assign v[0]   = start;
	assign acc[0] = {wide_limb_7, wide_limb_6, wide_limb_5, wide_limb_4,
		wide_limb_3, wide_limb_2, wide_limb_1, wide_limb_0};

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		mr256_round #(.ROUND(r)) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (v[r]),
			.in_acc    (acc[r]),
			.out_valid (v[r+1]),
			.out_acc   (acc[r+1])
		);
	end

	assign diff = {1'b0, acc[ROUNDS][8*LIMB_W-1:4*LIMB_W]} - {1'b0, cfg.modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= diff[4*LIMB_W] ? acc[ROUNDS][8*LIMB_W-1:4*LIMB_W] : diff[4*LIMB_W-1:0];
	end

	assign done           = done_q;
	assign reduced_limb_0 = res_q[63:0];
	assign reduced_limb_1 = res_q[127:64];
	assign reduced_limb_2 = res_q[191:128];
	assign reduced_limb_3 = res_q[255:192];
endmodule

// File: sim/mr256_checker.sv
// Checker for the Montgomery reducer: predicts each reduced word and compares.
`timescale 1ns / 100ps
module mr256_checker
	import mr256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] wide_limb_0,
	input  logic [63:0] wide_limb_1,
	input  logic [63:0] wide_limb_2,
	input  logic [63:0] wide_limb_3,
	input  logic [63:0] wide_limb_4,
	input  logic [63:0] wide_limb_5,
	input  logic [63:0] wide_limb_6,
	input  logic [63:0] wide_limb_7,
	input  logic        done,
	input  logic [63:0] reduced_limb_0,
	input  logic [63:0] reduced_limb_1,
	input  logic [63:0] reduced_limb_2,
	input  logic [63:0] reduced_limb_3,
	output int          mismatches,
	output int          pending,
	output int          words_checked
);
	limb_t mod_limb [4];
	limb_t ninv;
	elem_t reduced_q [$];

	function automatic elem_t mont_reduce(input wide_t t);
		limb_t w [8];
		limb_t k, carry_w, upper;
		logic [128:0] acc;
		logic [65:0] s;
		logic [64:0] d;
		limb_t diff [4];
		logic borrow;
		elem_t r;
		for (int i = 0; i < 8; i++) w[i] = t[i*64 +: 64];
		upper = 0;
		for (int i = 0; i < 4; i++) begin
			k = w[i] * ninv;
			carry_w = 0;
			for (int j = 0; j < 4; j++) begin
				acc = 129'(k) * 129'(mod_limb[j]) + 129'(w[i+j]) + 129'(carry_w);
				w[i+j] = acc[63:0];
				carry_w = acc[127:64];
			end
			s = 66'(w[i+4]) + 66'(upper) + 66'(carry_w);
			w[i+4] = s[63:0];
			upper = 64'(s[65:64]);
		end
		borrow = 0;
		for (int j = 0; j < 4; j++) begin
			d = 65'(w[4+j]) - 65'(mod_limb[j]) - 65'(borrow);
			diff[j] = d[63:0];
			borrow = d[64];
		end
		for (int j = 0; j < 4; j++) r[j*64 +: 64] = borrow ? w[4+j] : diff[j];
		return r;
	endfunction

	assign pending = reduced_q.size();

	always @(posedge clk or negedge arst_n) begin
		elem_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) mod_limb[i] = 0;
			ninv = 0;
			reduced_q.delete();
			mismatches = 0;
			words_checked = 0;
		end else begin
			if (done) begin
				got = {reduced_limb_3, reduced_limb_2, reduced_limb_1, reduced_limb_0};
				if (reduced_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", got);
				end else begin
					want = reduced_q.pop_front();
					words_checked++;
					for (int j = 0; j < 4; j++)
						if (got[j*64 +: 64] !== want[j*64 +: 64]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("limb %0d: expected %h got %h", j,
									want[j*64 +: 64], got[j*64 +: 64]);
						end
				end
			end
			if (start && !busy)
				reduced_q.push_back(mont_reduce({wide_limb_7, wide_limb_6, wide_limb_5,
					wide_limb_4, wide_limb_3, wide_limb_2, wide_limb_1, wide_limb_0}));
			if (cfg_we) begin
				if (cfg_index <= REG_MOD3) mod_limb[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == REG_NINV) ninv = cfg_data;
			end
		end
	end
endmodule

// File: sim/tb_montgomery_reduce_256_top.sv
// Testbench top: drives configuration and words into the reducer and gives the verdict.
`timescale 1ns / 100ps
module tb_montgomery_reduce_256_top;
	import mr256_pkg::*;
	logic clk = 0, arst_n = 0, cfg_we = 0, start = 0;
	logic [2:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic [63:0] wl [8];
	logic busy, done;
	logic [63:0] rl0, rl1, rl2, rl3;
	int mismatches, pending, words_checked, words_sent;

	initial for (int i = 0; i < 8; i++) wl[i] = 0;
	always #10 clk = ~clk;

	montgomery_reduce_256_top u_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
		.wide_limb_0(wl[0]), .wide_limb_1(wl[1]), .wide_limb_2(wl[2]),
		.wide_limb_3(wl[3]), .wide_limb_4(wl[4]), .wide_limb_5(wl[5]),
		.wide_limb_6(wl[6]), .wide_limb_7(wl[7]), .done,
		.reduced_limb_0(rl0), .reduced_limb_1(rl1), .reduced_limb_2(rl2),
		.reduced_limb_3(rl3));

	mr256_checker u_chk (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
		.wide_limb_0(wl[0]), .wide_limb_1(wl[1]), .wide_limb_2(wl[2]),
		.wide_limb_3(wl[3]), .wide_limb_4(wl[4]), .wide_limb_5(wl[5]),
		.wide_limb_6(wl[6]), .wide_limb_7(wl[7]), .done,
		.reduced_limb_0(rl0), .reduced_limb_1(rl1), .reduced_limb_2(rl2),
		.reduced_limb_3(rl3), .mismatches, .pending, .words_checked);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_limb();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1;
			default: return rand64();
		endcase
	endfunction

	// Newton iteration for -p0^-1 mod 2^64; p0 must be odd.
	function automatic logic [63:0] neg_inv_of(input logic [63:0] p0);
		logic [63:0] x;
		x = p0;
		for (int i = 0; i < 6; i++) x = x * (64'd2 - p0 * x);
		return -x;
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_modulus(input logic [63:0] p0, p1, p2, p3, ninv);
		cfg_write(REG_MOD0, p0);
		cfg_write(REG_MOD1, p1);
		cfg_write(REG_MOD2, p2);
		cfg_write(REG_MOD3, p3);
		cfg_write(REG_NINV, ninv);
	endtask

	task automatic send_word(input logic [63:0] w [8], input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		for (int i = 0; i < 8; i++) wl[i] <= w[i];
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Mostly values below p*2^256 with random content; some arbitrary.
	task automatic random_words(input int n, input logic [63:0] p3);
		logic [63:0] w [8];
		bit gaps;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) gaps = $urandom_range(0, 2) != 0;
			for (int i = 0; i < 8; i++) w[i] = pick_limb();
			if ($urandom_range(0, 9) < 8 && p3 != 0) w[7] = rand64() % p3;
			send_word(w, gaps);
		end
	endtask

	initial begin
		logic [63:0] w [8];
		logic [63:0] p0;
		words_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset configuration: zero modulus
		for (int i = 0; i < 8; i++) w[i] = rand64();
		send_word(w, 0);
		drain();
		// all-ones modulus
		load_modulus('1, '1, '1, '1, neg_inv_of('1));
		for (int i = 0; i < 8; i++) w[i] = 0;
		send_word(w, 0);
		for (int i = 0; i < 8; i++) w[i] = '1;
		send_word(w, 0);
		w[7] = 64'hFFFF_FFFF_FFFF_FFFE;
		send_word(w, 0);
		drain();
		// secp256k1-like prime
		load_modulus(64'hFFFFFFFEFFFFFC2F, '1, '1, '1, neg_inv_of(64'hFFFFFFFEFFFFFC2F));
		for (int i = 0; i < 8; i++) w[i] = 0;
		w[4] = 64'hFFFFFFFEFFFFFC2F; w[5] = '1; w[6] = '1; w[7] = '1;
		send_word(w, 0); // too large input
		for (int i = 0; i < 8; i++) w[i] = i[0] ? '1 : 0;
		send_word(w, 0);
		for (int i = 0; i < 8; i++) w[i] = 64'd1 << (i * 9);
		send_word(w, 0);
		drain();
		// even modulus with inconsistent constant; ignored index
		load_modulus(64'd2, 64'd0, 64'd0, 64'h8000_0000_0000_0000, 64'h1234_5678_9ABC_DEF0);
		cfg_write(3'd5, '1);
		cfg_write(3'd7, '1);
		for (int i = 0; i < 8; i++) w[i] = rand64();
		send_word(w, 0);
		drain();
		random_words(100, '1);
		drain();
		// random odd moduli
		for (int ph = 0; ph < 4; ph++) begin
			p0 = rand64() | 64'd1;
			load_modulus(p0, rand64(), rand64(), rand64() | 64'd1, neg_inv_of(p0));
			random_words(110, u_chk.mod_limb[3]);
			drain();
		end
		$display("Sent %0d words over zero, all-ones, pseudo-Mersenne, even and random moduli;",
			words_sent);
		$display("%0d results checked, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
